>>> hw/rtl/upd_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
package upd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // Up to three decoded bytes produced by one input item, in output order.
  // last applies to the final byte of the group only.
  typedef struct packed {
    logic [1:0] cnt_m1;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } group_t;

  typedef struct packed {
    phase_t phase;
  } front_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
        ((c >= 8'h61) && (c <= 8'h66));
    return r;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

>>> hw/rtl/upd_front.sv
// Front end: tracks the escape phase and turns each input item into a byte group.
module upd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                q_full,
  output logic                in_ready,
  output logic                push,
  output upd_pkg::group_t     grp,
  output upd_pkg::front_stat_t stat
);
  import upd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  logic       accept;
  logic       hex;
  logic       fresh_starts;
  logic       fresh_emit;
  logic [7:0] fresh_byte;
  logic [1:0] n_bytes;

  assign in_ready     = !q_full;
  assign accept       = in_valid && in_ready;
  assign hex          = is_hex(in_byte);
  assign fresh_starts = (in_byte == PCT_CHAR) && !in_last;
  assign fresh_emit   = !fresh_starts;
  assign fresh_byte   = (in_byte == PLUS_CHAR) ? SPACE_CHAR : in_byte;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (accept) begin
      unique case (phase_r)
        PH_PCT: begin
          if (hex && !in_last) begin
            phase_nxt = PH_DIGIT;
            held_nxt  = in_byte;
          end else begin
            phase_nxt = fresh_starts ? PH_PCT : PH_IDLE;
          end
        end
        PH_DIGIT: begin
          if (hex) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = fresh_starts ? PH_PCT : PH_IDLE;
          end
        end
        default: begin
          phase_nxt = fresh_starts ? PH_PCT : PH_IDLE;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    grp      = '0;
    n_bytes  = 2'd0;
    grp.last = in_last;
    unique case (phase_r)
      PH_PCT: begin
        if (!(hex && !in_last)) begin
          grp.b0  = PCT_CHAR;
          grp.b1  = fresh_byte;
          n_bytes = fresh_emit ? 2'd2 : 2'd1;
        end
      end
      PH_DIGIT: begin
        if (hex) begin
          grp.b0  = {hex_val(held_r), hex_val(in_byte)};
          n_bytes = 2'd1;
        end else begin
          grp.b0  = PCT_CHAR;
          grp.b1  = held_r;
          grp.b2  = fresh_byte;
          n_bytes = fresh_emit ? 2'd3 : 2'd2;
        end
      end
      default: begin
        grp.b0  = fresh_byte;
        n_bytes = fresh_emit ? 2'd1 : 2'd0;
      end
    endcase
    grp.cnt_m1 = n_bytes - 2'd1;
  end

  assign push       = accept && (n_bytes != 2'd0);
  assign stat.phase = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

>>> hw/rtl/upd_queue.sv
// Small flop queue of byte groups between front and back end.
module upd_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  upd_pkg::group_t push_grp,
  input  logic            pop,
  output upd_pkg::group_t head,
  output logic            full,
  output logic            empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import upd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  group_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/upd_back.sv
// Back end: serializes byte groups into the registered output stream.
module upd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  upd_pkg::group_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import upd_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       at_end;
  logic [7:0] sel_byte;

  assign load   = head_valid && (!valid_r || out_ready);
  assign at_end = (idx_r == head.cnt_m1);
  assign pop    = load && at_end;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.b0;
      2'd1:    sel_byte = head.b1;
      default: sel_byte = head.b2;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = sel_byte;
      last_nxt  = at_end && head.last;
      idx_nxt   = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

>>> hw/rtl/url_percent_decoder_unit.sv
// Top level of the URL percent decoder: front end, group queue, back end.
// Output path: an item that yields output reaches out_tvalid through the queue write and
//   then the registered output byte.
// Throughput with out_tready high: one input item per cycle while each yields at most one
//   byte; an item flushing a held escape yields up to three bytes, emitted one per cycle.
// Reset: synchronous active-low rst_n clears escape phase, queue pointers and output valid.
module url_percent_decoder_unit #(
  parameter int QUEUE_DEPTH = 4   // byte groups buffered between front and back, >= 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,    // in_last
  // output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast    // out_last
);
  import upd_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  group_t      push_grp;
  group_t      head;
  front_stat_t fstat;
  logic        push, pop;
  logic        q_full, q_empty;
  logic [CW-1:0] q_count;

  // front: classify bytes against the escape phase, one item per cycle while the queue is not full
  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .grp      (push_grp),
    .stat     (fstat)
  );

  // queue decouples input acceptance from output stalls
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  // back: one decoded byte per cycle into the output register, unless out_tready stalls it
  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

  // queue occupancy stays within its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // a string end always leaves no escape pending
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (fstat.phase == PH_IDLE))
    else $error("escape pending after last item");

  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  // a full queue blocks input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == CW'(QUEUE_DEPTH)) |-> !in_tready)
    else $error("input accepted while queue full");

endmodule

>>> sim/url_percent_decoder_unit_chk.sv
// Checker for the URL percent decoder: predicts decoded bytes and compares them on the output.
`timescale 1ns / 1ps

module url_percent_decoder_unit_chk (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  output int         err_cnt,
  output int         pending_cnt
);
  import upd_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dec_byte_t;

  dec_byte_t  decoded_q[$];
  phase_t     esc_phase  = PH_IDLE;
  logic [7:0] held_digit = 8'h00;
  int         errors     = 0;

  function automatic logic hex_ok(input logic [7:0] c);
    return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "F")) ||
           ((c >= "a") && (c <= "f"));
  endfunction

  // digits carry their value in the low nibble; letters are low nibble + 9
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  task automatic push_byte(input logic [7:0] c, input logic l);
    dec_byte_t e;
    e.ch      = c;
    e.last    = l;
    decoded_q = {decoded_q, e};
  endtask

  // a byte seen with no escape pending
  task automatic emit_fresh(input logic [7:0] b, input logic l);
    if ((b == PCT_CHAR) && !l) begin
      esc_phase = PH_PCT;
    end else if (b == PLUS_CHAR) begin
      push_byte(SPACE_CHAR, l);
    end else begin
      push_byte(b, l);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic l);
    phase_t ph;
    ph        = esc_phase;
    esc_phase = PH_IDLE;
    case (ph)
      PH_PCT: begin
        if (hex_ok(b) && !l) begin
          held_digit = b;
          esc_phase  = PH_DIGIT;
        end else begin
          push_byte(PCT_CHAR, 1'b0);
          emit_fresh(b, l);
        end
      end
      PH_DIGIT: begin
        if (hex_ok(b)) begin
          push_byte({hex_nib(held_digit), hex_nib(b)}, l);
        end else begin
          push_byte(PCT_CHAR, 1'b0);
          push_byte(held_digit, 1'b0);
          emit_fresh(b, l);
        end
      end
      default: emit_fresh(b, l);
    endcase
  endtask

  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst_n) begin
      decoded_q.delete();
      esc_phase  = PH_IDLE;
      held_digit = 8'h00;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected out item: out_byte %h out_last %b", out_tdata, out_tlast);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.ch) begin
            $error("out_byte: expected %h, actual %h", want.ch, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, out_tlast);
            errors++;
          end
        end
      end
    end
    pending_cnt = decoded_q.size();
    err_cnt     = errors;
  end

endmodule

>>> sim/url_percent_decoder_unit_tb.sv
// Testbench top for the URL percent decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module url_percent_decoder_unit_tb;
  import upd_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;     // [7:0] in_byte
  logic       in_tlast;     // in_last
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;    // [7:0] out_byte
  logic       out_tlast;    // out_last

  int         err_cnt;
  int         pending_cnt;

  // no random idling on either side while set
  logic       calm;
  int         sent_n;
  // encoded bytes of the string being built
  logic [7:0] enc_q[$];

  url_percent_decoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  url_percent_decoder_unit_chk i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .err_cnt    (err_cnt),
    .pending_cnt(pending_cnt)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: drops ready about 8 percent of the time, never while calm
  always @(negedge clk) begin
    out_tready = calm || ($urandom_range(99) >= 8);
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("[url_percent_decoder_unit] ERROR");
    $finish;
  end

  // Present one item at the falling edge, with an occasional gap first, and hold it
  // until the rising edge that takes it. valid stays high into the next item.
  task automatic send_item(input logic [7:0] b, input logic l);
    while (!calm && ($urandom_range(99) < 8)) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = b;
    in_tlast  = l;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_n++;
  endtask

  // random hex digit, digits and both letter cases
  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("A" + v - 10);
    return 8'("a" + v - 16);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    enc_q = {enc_q, b};
  endtask

  // One token of a string: mostly plain bytes, pluses and good escapes, with some
  // escapes broken after the percent or after the first digit.
  task automatic add_token();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      add_byte(8'($urandom_range(255)));
    end else if (r < 50) begin
      add_byte(PLUS_CHAR);
    end else if (r < 85) begin
      add_byte(PCT_CHAR);
      add_byte(rand_hex());
      add_byte(rand_hex());
    end else begin
      add_byte(PCT_CHAR);
      case ($urandom_range(2))
        0: ;                                   // lone percent, next token breaks it
        1: begin
          add_byte(rand_hex());
          add_byte(8'($urandom_range(255)));
        end
        default: add_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    int n_tok;
    calm      = 1'b0;
    sent_n    = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: byte extremes, plus, escapes in both cases
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(PLUS_CHAR, 1'b0);
    send_item(PCT_CHAR, 1'b0); send_item("4", 1'b0); send_item("1", 1'b0);
    send_item(PCT_CHAR, 1'b0); send_item("f", 1'b0); send_item("F", 1'b0);
    // non-hex right after the percent
    send_item(PCT_CHAR, 1'b0); send_item("G", 1'b0);
    // percent breaks an escape and starts another; plus breaks that one
    send_item(PCT_CHAR, 1'b0); send_item(PCT_CHAR, 1'b0); send_item(PLUS_CHAR, 1'b0);
    // percent breaks after the first digit, then a full escape ends the string
    send_item(PCT_CHAR, 1'b0); send_item("a", 1'b0); send_item(PCT_CHAR, 1'b0);
    send_item("0", 1'b0); send_item("0", 1'b1);
    // string ends with only the percent held
    send_item(PCT_CHAR, 1'b0); send_item("9", 1'b1);
    // lone percent carrying last
    send_item(PCT_CHAR, 1'b1);
    // three bytes out of one item, last on the space
    send_item(PCT_CHAR, 1'b0); send_item("B", 1'b0); send_item(PLUS_CHAR, 1'b1);
    send_item("z", 1'b1);

    // random strings; a stretch in the middle runs with no idling at all
    while (sent_n < 370) begin
      enc_q.delete();
      n_tok = $urandom_range(1, 10);
      repeat (n_tok) add_token();
      foreach (enc_q[i]) begin
        calm = (sent_n >= 150) && (sent_n < 230);
        send_item(enc_q[i], i == enc_q.size() - 1);
      end
    end
    calm      = 1'b0;
    in_tvalid = 1'b0;

    // drain, then wait for anything spurious to show up
    while (pending_cnt != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (err_cnt == 0) begin
      $display("[url_percent_decoder_unit] OK");
    end else begin
      $display("[url_percent_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
